>>> rtl/core/atmv_pkg.sv
// ----------------------------------------------------------------------------
// atmv_pkg
// Shared types and constants of the trimmed-mean ADC voltage unit.
// ----------------------------------------------------------------------------
package atmv_pkg;

  // Burst geometry
  localparam int unsigned SAMPLES_PER_CHANNEL = 7;
  localparam int unsigned CHANNELS            = 3;

  // Field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUM_W    = 15;
  localparam int unsigned SEEN_W   = 3;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned VOLT_W   = 13;
  localparam int unsigned REF_W    = 10;
  localparam int unsigned GAIN_W   = 3;
  localparam int unsigned FLOOR_W  = 10;
  localparam int unsigned SCALE_W  = REF_W;
  localparam int unsigned SCALE_SH = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FLOOR  = 2'd2;

  localparam logic [REF_W-1:0]   REF_VOLTAGE_RST = 10'd330;
  localparam logic [GAIN_W-1:0]  FIRST_GAIN_RST  = 3'd3;
  localparam logic [FLOOR_W-1:0] ZERO_FLOOR_RST  = 10'd100;

  // Trimmed divide: mean = (trimmed * DIV_RECIP) >> DIV_SHIFT, exact for 15-bit inputs
  localparam int unsigned TRIM_DIV  = SAMPLES_PER_CHANNEL - 2;
  localparam int unsigned DIV_SHIFT = 20;
  localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((2 ** DIV_SHIFT) + TRIM_DIV - 1) / TRIM_DIV);
  localparam int unsigned DIV_PROD_W = SUM_W + RECIP_W;

  localparam logic [SEEN_W-1:0] SEEN_LAST = SEEN_W'(SAMPLES_PER_CHANNEL);
  localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start_round;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [VOLT_W-1:0] voltage;
    logic              round_done;
  } out_req_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] largest;
    logic [SAMPLE_W-1:0] smallest;
    logic                last;
  } burst_t;

  typedef struct packed {
    logic [REF_W-1:0]   ref_voltage;
    logic [GAIN_W-1:0]  first_gain;
    logic [FLOOR_W-1:0] zero_floor;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCALE,
    BK_GAIN
  } back_state_e;

endpackage

>>> rtl/core/atmv_front.sv
// ----------------------------------------------------------------------------
// atmv_front
// Burst accumulator: running sum, minimum, maximum and channel tracking.
// ----------------------------------------------------------------------------
module atmv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  atmv_pkg::in_req_t   in_req_i,
  input  logic                q_full_i,
  output logic                in_stall_o,
  output logic                push_o,
  output atmv_pkg::burst_t    burst_o
);

  logic [atmv_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [atmv_pkg::SAMPLE_W-1:0] max_q, max_d;
  logic [atmv_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic [atmv_pkg::SEEN_W-1:0]   seen_q, seen_d, seen_eff, seen_inc;
  logic [atmv_pkg::CH_W-1:0]     ch_q, ch_d, ch_eff;
  logic                          accept, first, burst_end, ch_last;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    seen_eff  = in_req_i.start_round ? '0 : seen_q;
    ch_eff    = in_req_i.start_round ? '0 : ch_q;
    first     = (seen_eff == '0);
    seen_inc  = seen_eff + atmv_pkg::SEEN_W'(1);
    burst_end = (seen_inc == atmv_pkg::SEEN_LAST);
    ch_last   = (ch_eff == atmv_pkg::CH_LAST);

    if (first) begin
      sum_d = atmv_pkg::SUM_W'(in_req_i.sample);
      max_d = in_req_i.sample;
      min_d = in_req_i.sample;
    end else begin
      sum_d = sum_q + atmv_pkg::SUM_W'(in_req_i.sample);
      max_d = (in_req_i.sample > max_q) ? in_req_i.sample : max_q;
      min_d = (in_req_i.sample < min_q) ? in_req_i.sample : min_q;
    end

    if (burst_end) begin
      seen_d = '0;
      ch_d   = ch_last ? '0 : ch_eff + atmv_pkg::CH_W'(1);
    end else begin
      seen_d = seen_inc;
      ch_d   = ch_eff;
    end
  end

  assign push_o           = accept && burst_end;
  assign burst_o.channel  = ch_eff;
  assign burst_o.sum      = sum_d;
  assign burst_o.largest  = max_d;
  assign burst_o.smallest = min_d;
  assign burst_o.last     = ch_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      max_q  <= '0;
      min_q  <= '0;
      seen_q <= '0;
      ch_q   <= '0;
    end else if (accept) begin
      sum_q  <= sum_d;
      max_q  <= max_d;
      min_q  <= min_d;
      seen_q <= seen_d;
      ch_q   <= ch_d;
    end
  end

endmodule

>>> rtl/core/atmv_queue.sv
// ----------------------------------------------------------------------------
// atmv_queue
// Two-entry queue of finished bursts between accumulator and converter.
// ----------------------------------------------------------------------------
module atmv_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  atmv_pkg::burst_t       push_data_i,
  input  logic                   pop_i,
  output atmv_pkg::burst_t       pop_data_o,
  output logic                   empty_o,
  output logic                   full_o
);

  atmv_pkg::burst_t                 mem_q [atmv_pkg::QUEUE_DEPTH];
  logic [atmv_pkg::QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [atmv_pkg::QUEUE_CNT_W-1:0] cnt_q;
  logic                             do_push, do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == atmv_pkg::QUEUE_CNT_W'(atmv_pkg::QUEUE_DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + atmv_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + atmv_pkg::QUEUE_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + atmv_pkg::QUEUE_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - atmv_pkg::QUEUE_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/atmv_back.sv
// ----------------------------------------------------------------------------
// atmv_back
// Burst converter: trim, divide, scale by reference, gain, floor, output reg.
// ----------------------------------------------------------------------------
module atmv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  atmv_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  atmv_pkg::burst_t    q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atmv_pkg::out_req_t  out_req_o
);

  atmv_pkg::back_state_e state_q, state_d;

  logic [atmv_pkg::SUM_W-1:0]      trim_q;
  logic [atmv_pkg::SAMPLE_W-1:0]   mean_q;
  logic [atmv_pkg::SCALE_W-1:0]    scaled_q;
  logic [atmv_pkg::CH_W-1:0]       ch_q;
  logic                            last_q;
  logic                            out_valid_q;
  atmv_pkg::out_req_t              out_q;

  logic [atmv_pkg::DIV_PROD_W-1:0]                  div_prod;
  logic [atmv_pkg::REF_W+atmv_pkg::SAMPLE_W-1:0]    scale_prod;
  logic [atmv_pkg::VOLT_W-1:0]                      volt_raw, volt_fin;
  logic                                             out_free, load_out, pop;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      atmv_pkg::BK_IDLE:  if (!q_empty_i) state_d = atmv_pkg::BK_DIV;
      atmv_pkg::BK_DIV:   state_d = atmv_pkg::BK_SCALE;
      atmv_pkg::BK_SCALE: state_d = atmv_pkg::BK_GAIN;
      atmv_pkg::BK_GAIN: begin
        if (out_free) begin
          state_d = q_empty_i ? atmv_pkg::BK_IDLE : atmv_pkg::BK_DIV;
        end
      end
      default:            state_d = atmv_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    load_out = 1'b0;
    pop      = 1'b0;
    case (state_q)
      atmv_pkg::BK_IDLE: pop = !q_empty_i;
      atmv_pkg::BK_GAIN: begin
        load_out = out_free;
        pop      = out_free && !q_empty_i;
      end
      default: begin
        load_out = 1'b0;
        pop      = 1'b0;
      end
    endcase
  end

  assign pop_o = pop;

  // Datapath
  always_comb begin
    div_prod   = atmv_pkg::DIV_PROD_W'(trim_q) * atmv_pkg::DIV_PROD_W'(atmv_pkg::DIV_RECIP);
    scale_prod = (atmv_pkg::REF_W + atmv_pkg::SAMPLE_W)'(cfg_i.ref_voltage)
               * (atmv_pkg::REF_W + atmv_pkg::SAMPLE_W)'(mean_q);
    if (ch_q == '0) begin
      volt_raw = atmv_pkg::VOLT_W'(scaled_q) * atmv_pkg::VOLT_W'(cfg_i.first_gain);
    end else begin
      volt_raw = atmv_pkg::VOLT_W'(scaled_q);
    end
    volt_fin = (volt_raw < atmv_pkg::VOLT_W'(cfg_i.zero_floor)) ? '0 : volt_raw;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      trim_q <= q_data_i.sum - atmv_pkg::SUM_W'(q_data_i.largest)
                             - atmv_pkg::SUM_W'(q_data_i.smallest);
      ch_q   <= q_data_i.channel;
      last_q <= q_data_i.last;
    end
    if (state_q == atmv_pkg::BK_DIV) begin
      mean_q <= div_prod[atmv_pkg::DIV_SHIFT +: atmv_pkg::SAMPLE_W];
    end
    if (state_q == atmv_pkg::BK_SCALE) begin
      scaled_q <= scale_prod[atmv_pkg::SCALE_SH +: atmv_pkg::SCALE_W];
    end
    if (load_out) begin
      out_q.channel    <= ch_q;
      out_q.voltage    <= volt_fin;
      out_q.round_done <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atmv_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/core/adc_trimmed_mean_voltage_unit.sv
// ----------------------------------------------------------------------------
// adc_trimmed_mean_voltage_unit
// Trimmed-mean voltage monitor for a round of multiplexed ADC channels.
// ----------------------------------------------------------------------------
// Raw 12-bit samples arrive as requests on the input channel, a burst of
// SAMPLES_PER_CHANNEL samples per channel, channels visited in turn from 0 to
// CHANNELS-1; a request with start_round set opens a fresh burst on channel 0
// and drops any partial burst. The front accumulator takes one sample request
// per cycle while the queue is not full, keeping sum, minimum and maximum, and
// on a burst's last sample hands it to a two-entry queue. The back converter
// pops a burst, removes the extremes, divides by SAMPLES_PER_CHANNEL-2 with a
// reciprocal multiply, multiplies by ref_voltage and shifts right by 12,
// applies first_channel_gain on channel 0 and forces values under zero_floor
// to zero. Each burst passes the states BK_DIV (divide multiply), BK_SCALE
// (reference multiply) and BK_GAIN (gain and floor, held while the output
// register is stalled); from BK_IDLE the queue is popped first. The input
// stalls only when two finished bursts wait in the queue, which happens when
// the output side stalls. A result request carries channel, voltage in 10 mV
// units and round_done on the last channel of the round. It sits in an
// output register until taken. Configuration registers must be written by
// the user through the plain write port only while the unit is idle; the
// block does not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_voltage_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [atmv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [atmv_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  atmv_pkg::in_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output atmv_pkg::out_req_t                out_req_o
);

  atmv_pkg::cfg_t      cfg_q;
  atmv_pkg::burst_t    front_burst, queue_burst;
  logic                q_push, q_full, q_empty, q_pop;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_voltage <= atmv_pkg::REF_VOLTAGE_RST;
      cfg_q.first_gain  <= atmv_pkg::FIRST_GAIN_RST;
      cfg_q.zero_floor  <= atmv_pkg::ZERO_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atmv_pkg::CFG_REF_VOLTAGE: cfg_q.ref_voltage <= cfg_data_i[atmv_pkg::REF_W-1:0];
        atmv_pkg::CFG_FIRST_GAIN:  cfg_q.first_gain  <= cfg_data_i[atmv_pkg::GAIN_W-1:0];
        atmv_pkg::CFG_ZERO_FLOOR:  cfg_q.zero_floor  <= cfg_data_i[atmv_pkg::FLOOR_W-1:0];
        default:                   cfg_q <= cfg_q;
      endcase
    end
  end

  // Front: accept samples and close bursts
  atmv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .burst_o    (front_burst)
  );

  // Queue: hold finished bursts so each side stalls on its own
  atmv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_burst),
    .pop_i       (q_pop),
    .pop_data_o  (queue_burst),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  // Back: convert one burst into a voltage result
  atmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (queue_burst),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> verif/atmv_reading_checker.sv
// ----------------------------------------------------------------------------
// atmv_reading_checker
// Watches both request channels and the configuration port of the unit. It
// keeps its own copy of the burst accumulator and the registers, predicts the
// channel reading that closes each burst, and compares every result request
// with the oldest reading still waiting.
// ----------------------------------------------------------------------------
module atmv_reading_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [atmv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [atmv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  atmv_pkg::in_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  atmv_pkg::out_req_t              out_req_i,
  output int unsigned                     fail_cnt_o,
  output int unsigned                     waiting_o
);
  import atmv_pkg::*;

  localparam int unsigned SHOWN_MAX = 10;

  logic [REF_W-1:0]    ref_volt;
  logic [GAIN_W-1:0]   ch0_gain;
  logic [FLOOR_W-1:0]  floor_volt;

  logic [SUM_W-1:0]    burst_sum;
  logic [SAMPLE_W-1:0] burst_max;
  logic [SAMPLE_W-1:0] burst_min;
  logic [SEEN_W-1:0]   burst_seen;
  logic [CH_W-1:0]     burst_ch;

  out_req_t            expected_reading_q[$];
  int unsigned         fails;

  // Trimmed mean of the current burst, scaled to 10 mV units, with the channel 0 gain and the zero floor applied.
  function automatic logic [VOLT_W-1:0] predict_reading(input logic [CH_W-1:0] ch);
    logic [SUM_W-1:0] trimmed;
    int unsigned      mean;
    int unsigned      volts;
    trimmed = burst_sum - SUM_W'(burst_max) - SUM_W'(burst_min);
    mean    = int'(trimmed) / (SAMPLES_PER_CHANNEL - 2);
    volts   = (int'(ref_volt) * mean) >> SCALE_SH;
    if (ch == '0) volts = volts * int'(ch0_gain);
    if (volts < int'(floor_volt)) volts = 0;
    return VOLT_W'(volts);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    out_req_t            want;
    out_req_t            got;
    logic [SAMPLE_W-1:0] smp;
    if (!rst_ni) begin
      ref_volt   = REF_VOLTAGE_RST;
      ch0_gain   = FIRST_GAIN_RST;
      floor_volt = ZERO_FLOOR_RST;
      burst_sum  = '0;
      burst_max  = '0;
      burst_min  = '0;
      burst_seen = '0;
      burst_ch   = '0;
      expected_reading_q.delete();
      fails      = 0;
      fail_cnt_o <= 0;
      waiting_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REF_VOLTAGE: ref_volt   = cfg_data_i[REF_W-1:0];
          CFG_FIRST_GAIN:  ch0_gain   = cfg_data_i[GAIN_W-1:0];
          CFG_ZERO_FLOOR:  floor_volt = cfg_data_i[FLOOR_W-1:0];
          default: ;
        endcase
      end

      // Results leave only after their cause is registered, so pop first.
      if (out_valid_i && !out_stall_i) begin
        got = out_req_i;
        if (expected_reading_q.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MAX)
            $display("[%0t] reading with none pending: ch=%0d v=%0d rd=%0b",
                     $realtime, got.channel, got.voltage, got.round_done);
        end else begin
          want = expected_reading_q.pop_front();
          if (got.channel !== want.channel || got.voltage !== want.voltage ||
              got.round_done !== want.round_done) begin
            fails++;
            if (fails <= SHOWN_MAX)
              $display("[%0t] reading mismatch: exp ch=%0d v=%0d rd=%0b, got ch=%0d v=%0d rd=%0b",
                       $realtime, want.channel, want.voltage, want.round_done,
                       got.channel, got.voltage, got.round_done);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        smp = in_req_i.sample;
        // Start of round drops any partial burst.
        if (in_req_i.start_round) begin
          burst_seen = '0;
          burst_ch   = '0;
        end
        if (burst_seen == '0) begin
          burst_sum = SUM_W'(smp);
          burst_max = smp;
          burst_min = smp;
        end else begin
          burst_sum = burst_sum + SUM_W'(smp);
          if (smp > burst_max) burst_max = smp;
          if (smp < burst_min) burst_min = smp;
        end
        burst_seen = burst_seen + SEEN_W'(1);
        if (burst_seen >= SEEN_LAST) begin
          want.channel    = burst_ch;
          want.voltage    = predict_reading(burst_ch);
          want.round_done = (int'(burst_ch) + 1 >= CHANNELS);
          expected_reading_q.push_back(want);
          burst_seen = '0;
          burst_ch   = want.round_done ? '0 : burst_ch + CH_W'(1);
        end
      end

      fail_cnt_o <= fails;
      waiting_o  <= expected_reading_q.size();
    end
  end

endmodule

>>> verif/adc_trimmed_mean_voltage_unit_tb.sv
// ----------------------------------------------------------------------------
// adc_trimmed_mean_voltage_unit_tb
// Drives sample requests, register writes and output stalls into the unit;
// a separate checker predicts and compares every channel reading.
// ----------------------------------------------------------------------------
module adc_trimmed_mean_voltage_unit_tb;
  import atmv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  // Front, two-entry queue, three back stages and the output register.
  localparam int unsigned DRAIN_CYCLES = 16;
  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic [1:0] {
    SPREAD_FULL,
    SPREAD_CLUSTER,
    SPREAD_RAILS,
    SPREAD_LOW
  } spread_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_req;

  int unsigned           fail_cnt;
  int unsigned           waiting;
  int unsigned           cycle_cnt = 0;
  int unsigned           send_idle_pct = 38;
  int unsigned           recv_stall_pct = 83;

  always #5 clk = ~clk;

  adc_trimmed_mean_voltage_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  atmv_reading_checker reading_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .fail_cnt_o  (fail_cnt),
    .waiting_o   (waiting)
  );

  // Receiver: stall at random, one fresh decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: end the run if the unit hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one sample request and hold it until the unit takes it. Random
  // gaps before the request land on every phase of the burst.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_req.sample      <= smp;
    in_req.start_round <= start;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every predicted reading has come out.
  task automatic wait_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // Let the unit go fully idle before touching the registers.
  task automatic settle();
    wait_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; optionally poke the unused index.
  task automatic load_config(input logic [REF_W-1:0] ref_v, input logic [GAIN_W-1:0] gain,
                             input logic [FLOOR_W-1:0] floor_v, input logic poke_unused);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_REF_VOLTAGE;
    cfg_data <= CFG_DATA_W'(ref_v);
    @(posedge clk);
    cfg_idx  <= CFG_FIRST_GAIN;
    cfg_data <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_idx  <= CFG_ZERO_FLOOR;
    cfg_data <= CFG_DATA_W'(floor_v);
    @(posedge clk);
    if (poke_unused) begin
      cfg_idx  <= CFG_UNUSED_IDX;
      cfg_data <= CFG_DATA_W'($urandom_range(1023));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_e spread,
                                                      input logic [SAMPLE_W-1:0] center);
    case (spread)
      SPREAD_CLUSTER: return center ^ SAMPLE_W'($urandom_range(31));
      SPREAD_RAILS:   return $urandom_range(1) ? '1 : '0;
      SPREAD_LOW:     return SAMPLE_W'($urandom_range(255));
      default:        return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  // Mostly complete bursts with random content; some are cut short and
  // followed by a forced round start, a few requests are pure noise.
  task automatic run_random(input int unsigned n_reqs, input int pause_at);
    int unsigned         sent;
    int unsigned         len;
    int unsigned         i;
    logic                open_round;
    logic                cut_short;
    spread_e             spread;
    logic [SAMPLE_W-1:0] center;
    sent       = 0;
    open_round = 1'b1;
    while (sent < n_reqs) begin
      if ($urandom_range(99) < 5) begin
        if (int'(sent) == pause_at) wait_readings();
        send_sample(SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
        sent++;
        open_round = 1'b1;
      end else begin
        cut_short = ($urandom_range(99) < 10);
        len    = cut_short ? $urandom_range(1, SAMPLES_PER_CHANNEL - 1) : SAMPLES_PER_CHANNEL;
        spread = spread_e'($urandom_range(3));
        center = SAMPLE_W'($urandom_range(4095));
        if ($urandom_range(99) < 20) open_round = 1'b1;
        for (i = 0; i < len && sent < n_reqs; i++) begin
          if (int'(sent) == pause_at) wait_readings();
          send_sample(pick_sample(spread, center), (i == 0) && open_round);
          sent++;
        end
        open_round = cut_short;
      end
    end
  endtask

  initial begin : stim_b
    logic [SAMPLE_W-1:0] mix [0:6];
    int unsigned         i;
    mix = '{12'd0, 12'd4095, 12'd2048, 12'd1, 12'd4094, 12'd100, 12'd3000};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: full-scale burst on channel 0,
    // all-zero burst on channel 1, mixed extremes closing the round.
    for (i = 0; i < SAMPLES_PER_CHANNEL; i++) send_sample('1, i == 0);
    for (i = 0; i < SAMPLES_PER_CHANNEL; i++) send_sample('0, 1'b0);
    for (i = 0; i < SAMPLES_PER_CHANNEL; i++) send_sample(mix[i], 1'b0);
    // Start of round in the middle of a burst.
    send_sample(12'd1234, 1'b0);
    send_sample(12'd777, 1'b0);
    send_sample(12'd555, 1'b1);
    settle();

    // Sender idles often, receiver stalls most of the time.
    load_config('1, 3'd7, '0, 1'b0);
    run_random(150, -1);
    settle();

    // Reference zero and gain zero: every reading must read as zero.
    load_config('0, 3'd0, '1, 1'b0);
    run_random(28, -1);
    settle();

    // Roles swapped; pause once until the pipeline has drained.
    send_idle_pct  = 83;
    recv_stall_pct = 38;
    load_config(10'd512, 3'd0, '0, 1'b0);
    run_random(130, 60);
    settle();

    // Full rate on both sides with random register values.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_config(REF_W'($urandom_range(1023)), GAIN_W'($urandom_range(1, 7)),
                FLOOR_W'($urandom_range(300)), 1'b1);
    run_random(120, -1);
    settle();

    if (fail_cnt == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/atmv_pkg.sv
rtl/core/atmv_front.sv
rtl/core/atmv_queue.sv
rtl/core/atmv_back.sv
rtl/core/adc_trimmed_mean_voltage_unit.sv
verif/atmv_reading_checker.sv
verif/adc_trimmed_mean_voltage_unit_tb.sv
